// ===== src/scmf_pkg.sv =====
// Shared types and constants for the sparse complex multipath FIR.
// Used by every design module but the checker; depends on nothing else.
package scmf_pkg;

    localparam int MAX_TAPS   = 6;
    localparam int MAX_DELAY  = 63;
    localparam int DELAY_W    = 6;
    localparam int HIST_AW    = 6;
    localparam int HIST_DEPTH = 1 << HIST_AW;
    localparam int SMP_W      = 16;
    localparam int COEF_W     = 16;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int TAP_WORD_W = 38;

    // Tap word layout
    localparam int COEF_RE_LSB = 6;
    localparam int COEF_IM_LSB = 22;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_WORD_FIRST = 3'd1;

    localparam logic [CNT_W-1:0]      TAP_COUNT_RST = 3'd1;
    localparam logic [TAP_WORD_W-1:0] TAP_WORD0_RST = 38'd1048576;

    // One queued input item
    typedef struct packed {
        logic signed [SMP_W-1:0] im;
        logic signed [SMP_W-1:0] re;
        logic                    last;
    } t_item;

    // Decoded configuration handed to the datapath
    typedef struct packed {
        logic [MAX_TAPS-1:0]              active;
        logic [MAX_TAPS-1:0][DELAY_W-1:0] delay;
        logic [MAX_TAPS-1:0][COEF_W-1:0]  coef_re;
        logic [MAX_TAPS-1:0][COEF_W-1:0]  coef_im;
        logic [DELAY_W-1:0]               deepest;
    } t_cfg;

endpackage

// ===== src/scmf_cfg.sv =====
// Configuration registers: tap count and packed tap words, decoded for the datapath.
// Depends on scmf_pkg.
module scmf_cfg
    import scmf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [TAP_WORD_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [CNT_W-1:0]      r_tap_count;
    logic [TAP_WORD_W-1:0] r_tap_word [MAX_TAPS];
    logic [CNT_W-1:0]      w_n_act;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RST;
            for (int t = 0; t < MAX_TAPS; t++) begin
                r_tap_word[t] <= (t == 0) ? TAP_WORD0_RST : '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_TAP_COUNT) begin
                r_tap_count <= i_cfg_data[CNT_W-1:0];
            end
            for (int t = 0; t < MAX_TAPS; t++) begin
                if (i_cfg_index == CFG_IDX_W'(int'(REG_TAP_WORD_FIRST) + t)) begin
                    r_tap_word[t] <= i_cfg_data;
                end
            end
        end
    end

    // Clamp the count, decode each tap and find the largest active delay
    always_comb begin
        logic [DELAY_W-1:0] d;
        logic [DELAY_W-1:0] m;
        w_n_act = (r_tap_count > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : r_tap_count;
        m = '0;
        o_cfg = '0;
        for (int t = 0; t < MAX_TAPS; t++) begin
            d = r_tap_word[t][DELAY_W-1:0];
            if (d > DELAY_W'(MAX_DELAY)) begin
                d = DELAY_W'(MAX_DELAY);
            end
            o_cfg.active[t]  = (CNT_W'(t) < w_n_act);
            o_cfg.delay[t]   = d;
            o_cfg.coef_re[t] = r_tap_word[t][COEF_RE_LSB +: COEF_W];
            o_cfg.coef_im[t] = r_tap_word[t][COEF_IM_LSB +: COEF_W];
            if (o_cfg.active[t] && d > m) begin
                m = d;
            end
        end
        o_cfg.deepest = m;
    end

endmodule

// ===== src/scmf_front.sv =====
// Front end: accepts input items into a short queue ahead of the datapath.
// Depends on scmf_pkg.
module scmf_front
    import scmf_pkg::*;
#(
    parameter int QUEUE_LOG2 = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [31:0]      i_s_tdata,   // [15:0] sample_re, [31:16] sample_im
    input  logic             i_s_tlast,   // last_sample
    output logic             o_q_valid,
    output t_item            o_q_item,
    input  logic             i_q_pop
);

    localparam int DEPTH = 1 << QUEUE_LOG2;

    logic [QUEUE_LOG2:0] r_wp;
    logic [QUEUE_LOG2:0] r_rp;
    t_item               r_mem [DEPTH];
    logic                w_full;
    logic                w_push;

    assign w_full = (r_wp[QUEUE_LOG2] != r_rp[QUEUE_LOG2]) &&
                    (r_wp[QUEUE_LOG2-1:0] == r_rp[QUEUE_LOG2-1:0]);
    assign o_s_tready = !w_full;
    assign w_push     = i_s_tvalid && !w_full;
    assign o_q_valid  = (r_wp != r_rp);
    assign o_q_item   = r_mem[r_rp[QUEUE_LOG2-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp[QUEUE_LOG2-1:0]] <= '{im:   i_s_tdata[31:16],
                                               re:   i_s_tdata[15:0],
                                               last: i_s_tlast};
        end
    end

endmodule

// ===== src/scmf_back.sv =====
// Back end: flush sequencing, sample history memories, complex MAC pipeline
// and the output register. Depends on scmf_pkg.
module scmf_back
    import scmf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] out_re, [31:16] out_im
    output logic        o_m_tlast    // out_last
);

    localparam int NPAIR = (MAX_TAPS + 1) / 2;

    // ---------------- issue / flush control ----------------
    logic               w_en;
    logic               w_issue_smp;
    logic               w_issue_fl;
    logic               w_issue;
    logic               w_final;
    logic [31:0]        w_wdata;
    logic               r_flushing;
    logic [DELAY_W-1:0] r_left;
    logic [HIST_AW-1:0] r_wp;
    logic [HIST_DEPTH-1:0] r_hvalid;
    logic [HIST_AW-1:0] w_raddr [MAX_TAPS];
    logic [MAX_TAPS-1:0] w_use;
    logic [MAX_TAPS-1:0] w_byp;

    logic               r_out_valid;

    // Whole pipeline holds while a result waits on the receiver
    assign w_en        = !r_out_valid || i_m_tready;
    assign w_issue_smp = w_en && !r_flushing && i_q_valid;
    assign w_issue_fl  = w_en && r_flushing;
    assign w_issue     = w_issue_smp || w_issue_fl;
    assign o_q_pop     = w_issue_smp;
    assign w_final     = r_flushing ? (r_left == DELAY_W'(1))
                                    : (i_q_item.last && i_cfg.deepest == '0);
    assign w_wdata     = r_flushing ? '0 : {i_q_item.im, i_q_item.re};

    always_comb begin
        for (int t = 0; t < MAX_TAPS; t++) begin
            w_raddr[t] = r_wp - HIST_AW'(i_cfg.delay[t]);
            w_byp[t]   = (i_cfg.delay[t] == '0);
            w_use[t]   = i_cfg.active[t] && (w_byp[t] || r_hvalid[w_raddr[t]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flushing <= 1'b0;
            r_left     <= '0;
            r_wp       <= '0;
            r_hvalid   <= '0;
        end else begin
            if (w_issue_smp && i_q_item.last && i_cfg.deepest != '0) begin
                r_flushing <= 1'b1;
                r_left     <= i_cfg.deepest;
            end
            if (w_issue_fl) begin
                r_left <= r_left - 1'b1;
                if (r_left == DELAY_W'(1)) begin
                    r_flushing <= 1'b0;
                end
            end
            if (w_issue) begin
                r_wp <= r_wp + 1'b1;
                if (w_final) begin
                    r_hvalid <= '0;
                end else begin
                    r_hvalid[r_wp] <= 1'b1;
                end
            end
        end
    end

    // ---------------- history: one copy per tap read port ----------------
    logic [31:0] w_rd [MAX_TAPS];

    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_hist
        logic [31:0] mem [HIST_DEPTH];
        logic [31:0] r_rd;
        always_ff @(posedge i_clk) begin
            if (w_issue) begin
                mem[r_wp] <= w_wdata;
            end
            if (w_en) begin
                r_rd <= mem[w_raddr[g]];
            end
        end
        assign w_rd[g] = r_rd;
    end

    // ---------------- stage 1: read registered ----------------
    logic                r1_v, r1_last;
    logic [MAX_TAPS-1:0] r1_use, r1_byp;
    logic [31:0]         r1_new;

    // ---------------- stage 2: products ----------------
    logic                r2_v, r2_last;
    logic signed [31:0]  r2_rr [MAX_TAPS];
    logic signed [31:0]  r2_ii [MAX_TAPS];
    logic signed [31:0]  r2_ri [MAX_TAPS];
    logic signed [31:0]  r2_ir [MAX_TAPS];

    // ---------------- stage 3: per-tap complex terms ----------------
    logic                r3_v, r3_last;
    logic signed [32:0]  r3_re [MAX_TAPS];
    logic signed [32:0]  r3_im [MAX_TAPS];

    // ---------------- stage 4: pair sums ----------------
    logic                r4_v, r4_last;
    logic signed [33:0]  r4_re [NPAIR];
    logic signed [33:0]  r4_im [NPAIR];

    // ---------------- stage 5: totals ----------------
    logic                r5_v, r5_last;
    logic signed [35:0]  r5_re, r5_im;

    logic [15:0]         r_out_re, r_out_im;
    logic                r_out_last;

    logic [31:0]         w_smp [MAX_TAPS];
    logic signed [35:0]  w_sum_re, w_sum_im;

    function automatic logic [15:0] round_sat(input logic signed [35:0] acc);
        logic signed [36:0] b;
        logic signed [22:0] r;
        b = 37'(acc) + 37'sd8192;
        r = 23'(b >>> 14);
        if (r > 23'sd32767) begin
            return 16'h7FFF;
        end else if (r < -23'sd32768) begin
            return 16'h8000;
        end else begin
            return r[15:0];
        end
    endfunction

    always_comb begin
        for (int t = 0; t < MAX_TAPS; t++) begin
            w_smp[t] = !r1_use[t] ? '0 : (r1_byp[t] ? r1_new : w_rd[t]);
        end
        w_sum_re = '0;
        w_sum_im = '0;
        for (int p = 0; p < NPAIR; p++) begin
            w_sum_re = w_sum_re + 36'(r4_re[p]);
            w_sum_im = w_sum_im + 36'(r4_im[p]);
        end
    end

    // Valid and last flags through the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r5_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r1_v        <= w_issue;
            r2_v        <= r1_v;
            r3_v        <= r2_v;
            r4_v        <= r3_v;
            r5_v        <= r4_v;
            r_out_valid <= r5_v;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_last <= w_final;
            r1_use  <= w_use;
            r1_byp  <= w_byp;
            r1_new  <= w_wdata;

            r2_last <= r1_last;
            for (int t = 0; t < MAX_TAPS; t++) begin
                r2_rr[t] <= $signed(w_smp[t][15:0])  * $signed(i_cfg.coef_re[t]);
                r2_ii[t] <= $signed(w_smp[t][31:16]) * $signed(i_cfg.coef_im[t]);
                r2_ri[t] <= $signed(w_smp[t][15:0])  * $signed(i_cfg.coef_im[t]);
                r2_ir[t] <= $signed(w_smp[t][31:16]) * $signed(i_cfg.coef_re[t]);
            end

            r3_last <= r2_last;
            for (int t = 0; t < MAX_TAPS; t++) begin
                r3_re[t] <= 33'(r2_rr[t]) - 33'(r2_ii[t]);
                r3_im[t] <= 33'(r2_ri[t]) + 33'(r2_ir[t]);
            end

            r4_last <= r3_last;
            for (int p = 0; p < NPAIR; p++) begin
                if (2 * p + 1 < MAX_TAPS) begin
                    r4_re[p] <= 34'(r3_re[2*p]) + 34'(r3_re[2*p+1]);
                    r4_im[p] <= 34'(r3_im[2*p]) + 34'(r3_im[2*p+1]);
                end else begin
                    r4_re[p] <= 34'(r3_re[2*p]);
                    r4_im[p] <= 34'(r3_im[2*p]);
                end
            end

            r5_last <= r4_last;
            r5_re   <= w_sum_re;
            r5_im   <= w_sum_im;

            r_out_last <= r5_last;
            r_out_re   <= round_sat(r5_re);
            r_out_im   <= round_sat(r5_im);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_im, r_out_re};
    assign o_m_tlast  = r_out_last;

endmodule

// ===== src/sparse_complex_multipath_fir.sv =====
// Top level of the sparse complex multipath FIR (tapped-delay-line channel).
// Depends on scmf_pkg, scmf_cfg, scmf_front and scmf_back.
//
// Usage:
//   s_axis carries one complex Q1.15 sample per item (tdata low half real,
//   high half imaginary); tlast marks the last sample of a block.
//   m_axis returns one Q1.15 result per step; tlast marks the final result
//   of a flushed block. A last sample yields 1 + (largest active delay)
//   results, as the block feeds zeros through the history to drain it,
//   then clears the history.
//   The cfg channel writes tap_count (index 0) and tap words 0..5
//   (indexes 1..6); o_cfg_ready is always high. Write only while idle.
// Throughput: one result per clock while m_axis is not stalled and a sample or
//   flush step is pending; the six tap products are formed in parallel, each tap
//   reading its own copy of the 64-entry history.
// Path: an accepted item passes the queue, history read, multiply, tap combine,
//   pair add, total add and round/saturate registers on its way to m_axis.
// Reset: synchronous, active low; clears the queue, the flush sequencer,
//   the history valid bits and the pipeline, and loads default taps.
// Stall: while m_axis_tready is low with a result waiting, the datapath
//   holds; s_axis keeps taking items until the input queue is full.
module sparse_complex_multipath_fir
    import scmf_pkg::*;
#(
    parameter int QUEUE_LOG2 = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // [15:0] sample_re, [31:16] sample_im
    input  logic                  s_axis_tlast,   // last_sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // [15:0] out_re, [31:16] out_im
    output logic                  m_axis_tlast,   // out_last
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [TAP_WORD_W-1:0] i_cfg_data
);

    t_cfg  w_cfg;
    logic  w_q_valid;
    logic  w_q_pop;
    t_item w_q_item;

    // Register file and tap decode
    scmf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Accept items into the queue
    scmf_front #(
        .QUEUE_LOG2 (QUEUE_LOG2)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item),
        .i_q_pop    (w_q_pop)
    );

    // Step through samples and flush zeros, accumulate taps, drive results
    scmf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_q_pop    (w_q_pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule

// ===== src/scmf_chk.sv =====
// Port-level checker for the sparse complex multipath FIR, bound to the top level.
// Depends on sparse_complex_multipath_fir.
module scmf_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Drop all results in flight at reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // No result can reach the output sooner than the pipeline latency after reset
    a_rst_latency: assert property (@(posedge i_clk)
        !i_rst_n |-> ##6 !m_axis_tvalid)
        else $error("result appeared before pipeline latency");

    // Input queue is empty and ready after reset
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind sparse_complex_multipath_fir scmf_chk u_chk (.*);

// ===== tb/sparse_complex_multipath_fir_test.sv =====
// Self-checking testbench for the sparse complex multipath FIR channel.
// Needs scmf_pkg and the sparse_complex_multipath_fir RTL; reads no files.
// Predicts every result in SystemVerilog and checks it field by field.
`timescale 1ns / 1ps

module sparse_complex_multipath_fir_test;
    import scmf_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;     // lets the pipeline empty, with slack
    localparam int HOLD_CYCLES  = 300;    // long output stall to back up the input queue
    localparam int MAX_REPORTS  = 20;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 52;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED =
        CFG_IDX_W'(REG_TAP_WORD_FIRST + MAX_TAPS);

    // One channel output item
    typedef struct packed {
        logic signed [SMP_W-1:0] re;
        logic signed [SMP_W-1:0] im;
        logic                    last;
    } t_chan_out;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;   // [15:0] sample_re, [31:16] sample_im
    logic                  s_axis_tlast;   // last_sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;   // [15:0] out_re, [31:16] out_im
    logic                  m_axis_tlast;   // out_last
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [TAP_WORD_W-1:0] i_cfg_data;

    sparse_complex_multipath_fir dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Samples waiting to be offered, and channel outputs still owed by the block
    t_item     sample_q[$];
    t_chan_out chan_out_q[$];

    // Shadow copy of the channel: tap registers and the delay line
    logic [CNT_W-1:0]      sh_tap_count;
    logic [TAP_WORD_W-1:0] sh_tap_word [MAX_TAPS];
    logic [2*SMP_W-1:0]    sh_delay_line [HIST_DEPTH];

    logic in_taken;
    logic src_idle_en;
    logic sink_idle_en;
    logic sink_hold;
    logic hold_go;
    int   error_count;
    int   cycle_count;

    // Clock: 10 ns period
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Channel predictor
    // ---------------------------------------------------------------

    // Tap count above the tap array size clamps to the array size.
    function automatic int active_taps();
        return (int'(sh_tap_count) > MAX_TAPS) ? MAX_TAPS : int'(sh_tap_count);
    endfunction

    // Newest sample goes to position 0; the oldest falls off the end.
    function automatic void shift_in(logic [SMP_W-1:0] re, logic [SMP_W-1:0] im);
        int k;
        for (k = HIST_DEPTH - 1; k > 0; k--)
            sh_delay_line[k] = sh_delay_line[k-1];
        sh_delay_line[0] = {im, re};
    endfunction

    // Round half up at bit 13, floor shift by 14, then clip to Q1.15.
    function automatic logic signed [SMP_W-1:0] round_sat(longint acc);
        longint r;
        r = (acc + 64'sd8192) >>> 14;
        if (r > 32767)
            r = 32767;
        else if (r < -32768)
            r = -32768;
        return r[SMP_W-1:0];
    endfunction

    // Sum of coefficient times delayed sample over the active taps.
    function automatic t_chan_out tap_sum(logic last);
        t_chan_out res;
        longint    acc_re, acc_im, sr, si, cr, ci;
        int        t, d;
        acc_re = 0;
        acc_im = 0;
        for (t = 0; t < active_taps(); t++) begin
            d  = int'(sh_tap_word[t][DELAY_W-1:0]);
            sr = $signed(sh_delay_line[d][SMP_W-1:0]);
            si = $signed(sh_delay_line[d][2*SMP_W-1:SMP_W]);
            cr = $signed(sh_tap_word[t][COEF_RE_LSB +: COEF_W]);
            ci = $signed(sh_tap_word[t][COEF_IM_LSB +: COEF_W]);
            acc_re += sr * cr - si * ci;
            acc_im += sr * ci + si * cr;
        end
        res.re   = round_sat(acc_re);
        res.im   = round_sat(acc_im);
        res.last = last;
        return res;
    endfunction

    // One accepted sample: one output, or on a last sample one output plus
    // one per zero fed through the line, then the line is cleared.
    function automatic void channel_step(t_item it);
        int t, k, maxd;
        shift_in(it.re, it.im);
        if (!it.last) begin
            chan_out_q.push_back(tap_sum(1'b0));
        end else begin
            maxd = 0;
            for (t = 0; t < active_taps(); t++)
                if (int'(sh_tap_word[t][DELAY_W-1:0]) > maxd)
                    maxd = int'(sh_tap_word[t][DELAY_W-1:0]);
            chan_out_q.push_back(tap_sum(maxd == 0));
            for (k = 1; k <= maxd; k++) begin
                shift_in('0, '0);
                chan_out_q.push_back(tap_sum(k == maxd));
            end
            for (k = 0; k < HIST_DEPTH; k++)
                sh_delay_line[k] = '0;
        end
    endfunction

    function automatic void shadow_reset();
        int k;
        sh_tap_count = TAP_COUNT_RST;
        for (k = 0; k < MAX_TAPS; k++)
            sh_tap_word[k] = '0;
        sh_tap_word[0] = TAP_WORD0_RST;
        for (k = 0; k < HIST_DEPTH; k++)
            sh_delay_line[k] = '0;
    endfunction

    // Unknown indexes drop the write; the count keeps only its own bits.
    function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx,
                                         logic [TAP_WORD_W-1:0] val);
        if (idx == REG_TAP_COUNT)
            sh_tap_count = val[CNT_W-1:0];
        else if (idx >= REG_TAP_WORD_FIRST && idx < REG_TAP_WORD_FIRST + MAX_TAPS)
            sh_tap_word[idx - REG_TAP_WORD_FIRST] = val;
    endfunction

    // ---------------------------------------------------------------
    // Monitor: track handshakes at the rising edge and check outputs
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_chan_out got, want;
        if (!i_rst_n) begin
            shadow_reset();
            in_taken <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                shadow_write(i_cfg_index, i_cfg_data);
            // Predict before checking so a same-edge output finds its entry
            if (s_axis_tvalid && s_axis_tready)
                channel_step('{re: s_axis_tdata[15:0], im: s_axis_tdata[31:16],
                               last: s_axis_tlast});
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got.re   = m_axis_tdata[15:0];
                got.im   = m_axis_tdata[31:16];
                got.last = m_axis_tlast;
                if (chan_out_q.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected output re=%0d im=%0d last=%0b",
                                 $time, got.re, got.im, got.last);
                end else begin
                    want = chan_out_q.pop_front();
                    if (got.re !== want.re || got.im !== want.im ||
                        got.last !== want.last) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display({"%0t: mismatch expected re=%0d im=%0d last=%0b,",
                                      " actual re=%0d im=%0d last=%0b"},
                                     $time, want.re, want.im, want.last,
                                     got.re, got.im, got.last);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sample driver: advance on acceptance, idle at random
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin : sample_driver
        t_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (sample_q.size() != 0 && !(src_idle_en && $urandom_range(99) < 15)) begin
                it = sample_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {it.im, it.re};
                s_axis_tlast  <= it.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output ready: random stalls, plus the long hold-off when requested
    always @(negedge i_clk) begin
        if (!i_rst_n || sink_hold)
            m_axis_tready <= 1'b0;
        else if (sink_idle_en)
            m_axis_tready <= ($urandom_range(99) >= 15);
        else
            m_axis_tready <= 1'b1;
    end

    // Long output stall, counted here, while the sender keeps offering
    initial begin : sink_stall
        int k;
        sink_hold = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        for (k = 0; k < HOLD_CYCLES; k++)
            @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic [TAP_WORD_W-1:0] tap_word(int delay, logic [15:0] cre,
                                                      logic [15:0] cim);
        return {cim, cre, DELAY_W'(delay)};
    endfunction

    function automatic void add_sample(logic [15:0] re, logic [15:0] im, logic last);
        t_item it;
        it.re   = re;
        it.im   = im;
        it.last = last;
        sample_q.push_back(it);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TAP_WORD_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold until every sample is in and every output is out, then let the
    // pipeline empty before touching the registers again.
    task automatic settle();
        while (sample_q.size() != 0 || s_axis_tvalid || chan_out_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_coef();
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(8191) - 4096);
    endfunction

    // Random tap set; short delays unless a long-delay phase is asked for.
    task automatic random_taps(bit long_delays);
        int k, cnt;
        if ($urandom_range(9) < 8)
            cnt = $urandom_range(MAX_TAPS, 1);
        else
            cnt = $urandom_range(1) ? 0 : 7;
        write_reg(REG_TAP_COUNT, {3'($urandom), 32'($urandom), 3'(cnt)});
        for (k = 0; k < MAX_TAPS; k++)
            write_reg(CFG_IDX_W'(REG_TAP_WORD_FIRST + k),
                      tap_word(long_delays ? $urandom_range(MAX_DELAY) : $urandom_range(7),
                               rand_coef(), rand_coef()));
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, {6'($urandom), 32'($urandom)});
    endtask

    task automatic queue_random(int count);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(3) == 0)
                add_sample(16'($urandom_range(511) - 256), 16'($urandom_range(511) - 256),
                           $urandom_range(11) == 0);
            else
                add_sample(16'($urandom), 16'($urandom), $urandom_range(11) == 0);
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        int p;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        in_taken      = 1'b0;
        src_idle_en   = 1'b1;
        sink_idle_en  = 1'b1;
        hold_go       = 1'b0;
        error_count   = 0;
        cycle_count   = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default taps (pass-through): field extremes, last sample with zero delay
        add_sample(16'h7FFF, 16'h8000, 1'b0);
        add_sample(16'h8000, 16'h7FFF, 1'b0);
        add_sample(16'h0000, 16'h0000, 1'b0);
        add_sample(16'h0001, 16'hFFFF, 1'b0);
        add_sample(16'h8000, 16'h8000, 1'b1);
        settle();

        // All six taps, extreme coefficients, longest delay: saturation and a
        // full 64-output flush
        write_reg(REG_TAP_COUNT, 38'(MAX_TAPS));
        write_reg(CFG_IDX_W'(REG_TAP_WORD_FIRST + 0), tap_word(0, 16'h7FFF, 16'h8000));
        write_reg(CFG_IDX_W'(REG_TAP_WORD_FIRST + 1),
                  tap_word(MAX_DELAY, 16'h8000, 16'h8000));
        write_reg(CFG_IDX_W'(REG_TAP_WORD_FIRST + 2), tap_word(1, 16'h7FFF, 16'h7FFF));
        write_reg(CFG_IDX_W'(REG_TAP_WORD_FIRST + 3), tap_word(5, 16'h8000, 16'h7FFF));
        write_reg(CFG_IDX_W'(REG_TAP_WORD_FIRST + 4), tap_word(2, 16'h0000, 16'h0001));
        write_reg(CFG_IDX_W'(REG_TAP_WORD_FIRST + 5), tap_word(62, 16'h0001, 16'h0000));
        add_sample(16'h7FFF, 16'h7FFF, 1'b0);
        add_sample(16'h8000, 16'h8000, 1'b0);
        add_sample(16'h7FFF, 16'h8000, 1'b0);
        add_sample(16'h8000, 16'h7FFF, 1'b0);
        add_sample(16'h5555, 16'hAAAA, 1'b1);
        settle();

        // Half-scale taps: exact ties round toward plus infinity
        write_reg(REG_TAP_COUNT, 38'd1);
        write_reg(CFG_IDX_W'(REG_TAP_WORD_FIRST + 0), tap_word(3, 16'd8192, 16'hE000));
        add_sample(16'h0001, 16'hFFFF, 1'b0);
        add_sample(16'hFFFF, 16'h0001, 1'b0);
        add_sample(16'h0003, 16'h0003, 1'b0);
        add_sample(16'hFFFD, 16'hFFFD, 1'b1);
        settle();

        // No taps active; upper data bits set and an unknown index must be ignored
        write_reg(REG_TAP_COUNT, 38'h3F_FFFF_FFF8);
        write_reg(REG_UNUSED, '1);
        add_sample(16'h7FFF, 16'h7FFF, 1'b0);
        add_sample(16'h1234, 16'h8765, 1'b1);
        settle();

        // Tap count beyond the array clamps to all six
        write_reg(REG_TAP_COUNT, 38'h2A_5A5A_5A5F);
        add_sample(16'h4000, 16'hC000, 1'b0);
        add_sample(16'h0100, 16'hFF00, 1'b1);
        settle();

        // Random phases: long delays in two, the long stall in one, and one
        // phase with no idling on either side
        for (p = 0; p < RAND_PHASES; p++) begin
            @(posedge i_clk);
            src_idle_en  = (p != 5);
            sink_idle_en = (p != 5);
            random_taps(p == 2 || p == 6);
            if (p == 3)
                hold_go = 1'b1;
            queue_random(PHASE_ITEMS);
            settle();
        end

        if (error_count == 0 && chan_out_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/scmf_pkg.sv
src/scmf_cfg.sv
src/scmf_front.sv
src/scmf_back.sv
src/sparse_complex_multipath_fir.sv
src/scmf_chk.sv
tb/sparse_complex_multipath_fir_test.sv
